/* hdl/bbve_pkg.sv */
// ----------------------------------------------------------------------------
// bbve_pkg
// Shared widths, payload types, slant table, vertex order table and color
// arithmetic for the beveled box vertex emitter.
// ----------------------------------------------------------------------------
package bbve_pkg;

  // coordinate width, signed fixed point with 8 fraction bits
  localparam int COORD_WIDTH = 32;
  localparam int ZW          = 31;
  localparam int HW          = 24;
  localparam int TW          = 4;
  localparam int CHW         = 8;
  localparam int KW          = 15;
  localparam int PW          = COORD_WIDTH + KW;
  localparam int CMPW        = (COORD_WIDTH > HW) ? COORD_WIDTH : HW;
  localparam int NUM_VERTS   = 30;
  localparam int VIDX_W      = 5;
  localparam int TOP_FIRST   = 24;

  localparam logic [VIDX_W-1:0] VIDX_LAST  = VIDX_W'(NUM_VERTS - 1);
  localparam logic [VIDX_W-1:0] VIDX_TOP   = VIDX_W'(TOP_FIRST);
  localparam logic [CHW-1:0]    CHAN_FULL  = '1;
  localparam logic [CHW-1:0]    CHAN_ZERO  = '0;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ZW-1:0]                 zval_t;

  typedef struct packed {
    logic [CHW-1:0] red;
    logic [CHW-1:0] green;
    logic [CHW-1:0] blue;
  } rgb_t;

  // one box as it arrives
  typedef struct packed {
    coord_t         corner_x0;
    coord_t         corner_y0;
    coord_t         corner_x1;
    coord_t         corner_y1;
    zval_t          base_z;
    logic [HW-1:0]  box_height;
    logic [TW-1:0]  node_type;
    logic [CHW-1:0] color_red;
    logic [CHW-1:0] color_green;
    logic [CHW-1:0] color_blue;
    logic           color_present;
    logic           selected;
  } box_t;

  // fully resolved box: footprint, inset edges, heights and face colors
  typedef struct packed {
    coord_t x0;
    coord_t x1;
    coord_t y0;
    coord_t y1;
    coord_t lx;
    coord_t rx;
    coord_t fy;
    coord_t ry;
    zval_t  z0;
    zval_t  zt;
    rgb_t   top;
    rgb_t   side;
  } corners_t;

  // one emitted vertex
  typedef struct packed {
    coord_t         vert_x;
    coord_t         vert_y;
    zval_t          vert_z;
    logic [CHW-1:0] out_red;
    logic [CHW-1:0] out_green;
    logic [CHW-1:0] out_blue;
    logic           last_vertex;
  } vert_t;

  // box corners: bottom ring then inset top ring
  typedef enum logic [2:0] {
    CRN_BL,
    CRN_BR,
    CRN_FR,
    CRN_FL,
    CRN_TBL,
    CRN_TBR,
    CRN_TFR,
    CRN_TFL
  } corner_e;

  // slant per node type, Q0.16
  function automatic logic [KW-1:0] slant_q16(logic [TW-1:0] t);
    logic [KW-1:0] k;
    unique case (t)
      4'd1:       k = KW'(2097);
      4'd2:       k = KW'(4194);
      4'd3:       k = KW'(21823);
      4'd6, 4'd7: k = KW'(16384);
      default:    k = '0;
    endcase
    return k;
  endfunction

  // vertex index to corner: rear, right, front, left, top quads
  function automatic corner_e vert_corner(logic [VIDX_W-1:0] idx);
    corner_e c;
    unique case (idx)
      5'd0:    c = CRN_BL;
      5'd1:    c = CRN_TBL;
      5'd2:    c = CRN_TBR;
      5'd3:    c = CRN_BL;
      5'd4:    c = CRN_TBR;
      5'd5:    c = CRN_BR;
      5'd6:    c = CRN_BR;
      5'd7:    c = CRN_TBR;
      5'd8:    c = CRN_TFR;
      5'd9:    c = CRN_BR;
      5'd10:   c = CRN_TFR;
      5'd11:   c = CRN_FR;
      5'd12:   c = CRN_FR;
      5'd13:   c = CRN_TFR;
      5'd14:   c = CRN_TFL;
      5'd15:   c = CRN_FR;
      5'd16:   c = CRN_TFL;
      5'd17:   c = CRN_FL;
      5'd18:   c = CRN_FL;
      5'd19:   c = CRN_TFL;
      5'd20:   c = CRN_TBL;
      5'd21:   c = CRN_FL;
      5'd22:   c = CRN_TBL;
      5'd23:   c = CRN_BL;
      5'd24:   c = CRN_TFL;
      5'd25:   c = CRN_TFR;
      5'd26:   c = CRN_TBR;
      5'd27:   c = CRN_TFL;
      5'd28:   c = CRN_TBR;
      5'd29:   c = CRN_TBL;
      default: c = CRN_BL;
    endcase
    return c;
  endfunction

  // c * 0.65 rounded half up: (c*13+10)/20, as ((v>>2)*205)>>10
  function automatic logic [CHW-1:0] shade(logic [CHW-1:0] c);
    logic [11:0] v;
    logic [17:0] q;
    v = 12'(c) * 12'd13 + 12'd10;
    q = 18'(v[11:2]) * 18'd205;
    return q[17:10];
  endfunction

  // c + 0.6*(255-c) rounded half up, /5 as *205>>10
  function automatic logic [CHW-1:0] brighten(logic [CHW-1:0] c);
    logic [9:0]  v;
    logic [17:0] q;
    v = 10'(CHAN_FULL - c) * 10'd3 + 10'd2;
    q = 18'(v) * 18'd205;
    return c + q[17:10];
  endfunction

  function automatic rgb_t shade_rgb(rgb_t c);
    rgb_t r;
    r.red   = shade(c.red);
    r.green = shade(c.green);
    r.blue  = shade(c.blue);
    return r;
  endfunction

  function automatic rgb_t brighten_rgb(rgb_t c);
    rgb_t r;
    r.red   = brighten(c.red);
    r.green = brighten(c.green);
    r.blue  = brighten(c.blue);
    return r;
  endfunction

endpackage

/* hdl/bbve_ifs.sv */
// ----------------------------------------------------------------------------
// bbve_ifs
// Valid/ready channel interfaces for box beats in and vertex beats out.
// ----------------------------------------------------------------------------
interface bbve_box_if
  import bbve_pkg::*;
();
  logic           valid;
  logic           ready;
  coord_t         corner_x0;
  coord_t         corner_y0;
  coord_t         corner_x1;
  coord_t         corner_y1;
  zval_t          base_z;
  logic [HW-1:0]  box_height;
  logic [TW-1:0]  node_type;
  logic [CHW-1:0] color_red;
  logic [CHW-1:0] color_green;
  logic [CHW-1:0] color_blue;
  logic           color_present;
  logic           selected;

  modport source (
    output valid, corner_x0, corner_y0, corner_x1, corner_y1, base_z, box_height,
           node_type, color_red, color_green, color_blue, color_present, selected,
    input  ready
  );
  modport sink (
    input  valid, corner_x0, corner_y0, corner_x1, corner_y1, base_z, box_height,
           node_type, color_red, color_green, color_blue, color_present, selected,
    output ready
  );
endinterface

interface bbve_vert_if
  import bbve_pkg::*;
();
  logic           valid;
  logic           ready;
  coord_t         vert_x;
  coord_t         vert_y;
  zval_t          vert_z;
  logic [CHW-1:0] out_red;
  logic [CHW-1:0] out_green;
  logic [CHW-1:0] out_blue;
  logic           last_vertex;

  modport source (
    output valid, vert_x, vert_y, vert_z, out_red, out_green, out_blue, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, vert_z, out_red, out_green, out_blue, last_vertex,
    output ready
  );
endinterface

/* hdl/bbve_geom_pipe.sv */
// ----------------------------------------------------------------------------
// bbve_geom_pipe
// Four-stage pipeline that turns one box into its eight corners, two heights
// and two face colors: extents, slant products, clamp, saturating inset.
// ----------------------------------------------------------------------------
module bbve_geom_pipe
  import bbve_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  box_t     box_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output corners_t corners_o
);

  localparam logic signed [COORD_WIDTH+1:0] SUM_MAX =
    $signed({3'b000, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [COORD_WIDTH+1:0] SUM_MIN =
    $signed({3'b111, {(COORD_WIDTH-1){1'b0}}});

  typedef struct packed {
    coord_t                 x0;
    coord_t                 x1;
    coord_t                 y0;
    coord_t                 y1;
    logic                   inv_x;
    logic                   inv_y;
    logic [COORD_WIDTH-1:0] wx;
    logic [COORD_WIDTH-1:0] wy;
    logic [KW-1:0]          k;
    logic [HW-1:0]          h;
    zval_t                  z0;
    zval_t                  zt;
    rgb_t                   top;
    rgb_t                   side;
    logic                   sel;
  } s1_t;

  typedef struct packed {
    coord_t        x0;
    coord_t        x1;
    coord_t        y0;
    coord_t        y1;
    logic          inv_x;
    logic          inv_y;
    logic [PW-1:0] prod_x;
    logic [PW-1:0] prod_y;
    logic [HW-1:0] h;
    zval_t         z0;
    zval_t         zt;
    rgb_t          top;
    rgb_t          side;
  } s2_t;

  typedef struct packed {
    coord_t                 x0;
    coord_t                 x1;
    coord_t                 y0;
    coord_t                 y1;
    logic                   inv_x;
    logic                   inv_y;
    logic [COORD_WIDTH-1:0] ox;
    logic [COORD_WIDTH-1:0] oy;
    zval_t                  z0;
    zval_t                  zt;
    rgb_t                   top;
    rgb_t                   side;
  } s3_t;

  // move a coordinate by a magnitude, saturating to the signed range
  function automatic coord_t sat_move(coord_t base, logic up,
                                      logic [COORD_WIDTH-1:0] mag);
    logic signed [COORD_WIDTH+1:0] b;
    logic signed [COORD_WIDTH+1:0] m;
    logic signed [COORD_WIDTH+1:0] s;
    coord_t                        r;
    b = {{2{base[COORD_WIDTH-1]}}, base};
    m = $signed({2'b00, mag});
    s = up ? (b + m) : (b - m);
    if (s > SUM_MAX) begin
      r = SUM_MAX[COORD_WIDTH-1:0];
    end else if (s < SUM_MIN) begin
      r = SUM_MIN[COORD_WIDTH-1:0];
    end else begin
      r = s[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // inset of one axis: product without fraction, height limit on ordered axes
  function automatic logic [COORD_WIDTH-1:0] clamp_inset(logic [PW-1:0] prod,
                                                         logic inv,
                                                         logic [HW-1:0] h);
    logic [CMPW-1:0]        p;
    logic [CMPW-1:0]        hh;
    logic [COORD_WIDTH-1:0] r;
    p  = CMPW'(prod[PW-1:16]);
    hh = CMPW'(h);
    if (!inv && (p > hh)) begin
      r = COORD_WIDTH'(hh);
    end else begin
      r = COORD_WIDTH'(p);
    end
    return r;
  endfunction

  logic     v1_q, v2_q, v3_q, v4_q;
  logic     rdy1, rdy2, rdy3, rdy4;
  s1_t      s1_d, s1_q;
  s2_t      s2_d, s2_q;
  s3_t      s3_d, s3_q;
  corners_t s4_d, s4_q;

  // stall chain: a stage moves when it is empty or its successor moves
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: extents, slant lookup, top height, base and shaded color
  always_comb begin
    rgb_t base_c;
    logic [ZW:0] zsum;
    s1_d.x0    = box_i.corner_x0;
    s1_d.x1    = box_i.corner_x1;
    s1_d.y0    = box_i.corner_y0;
    s1_d.y1    = box_i.corner_y1;
    s1_d.inv_x = box_i.corner_x1 < box_i.corner_x0;
    s1_d.inv_y = box_i.corner_y1 < box_i.corner_y0;
    s1_d.wx    = s1_d.inv_x ? COORD_WIDTH'(box_i.corner_x0 - box_i.corner_x1)
                            : COORD_WIDTH'(box_i.corner_x1 - box_i.corner_x0);
    s1_d.wy    = s1_d.inv_y ? COORD_WIDTH'(box_i.corner_y0 - box_i.corner_y1)
                            : COORD_WIDTH'(box_i.corner_y1 - box_i.corner_y0);
    s1_d.k     = slant_q16(box_i.node_type);
    s1_d.h     = box_i.box_height;
    s1_d.z0    = box_i.base_z;
    zsum       = (ZW+1)'(box_i.base_z) + (ZW+1)'(box_i.box_height);
    s1_d.zt    = zsum[ZW] ? '1 : zsum[ZW-1:0];
    if (box_i.color_present) begin
      base_c.red   = box_i.color_red;
      base_c.green = box_i.color_green;
      base_c.blue  = box_i.color_blue;
    end else begin
      base_c.red   = CHAN_FULL;
      base_c.green = CHAN_ZERO;
      base_c.blue  = CHAN_ZERO;
    end
    s1_d.top  = base_c;
    s1_d.side = shade_rgb(base_c);
    s1_d.sel  = box_i.selected;
  end

  // stage 2: slant products, highlight
  always_comb begin
    s2_d.x0     = s1_q.x0;
    s2_d.x1     = s1_q.x1;
    s2_d.y0     = s1_q.y0;
    s2_d.y1     = s1_q.y1;
    s2_d.inv_x  = s1_q.inv_x;
    s2_d.inv_y  = s1_q.inv_y;
    s2_d.prod_x = PW'(s1_q.wx) * PW'(s1_q.k);
    s2_d.prod_y = PW'(s1_q.wy) * PW'(s1_q.k);
    s2_d.h      = s1_q.h;
    s2_d.z0     = s1_q.z0;
    s2_d.zt     = s1_q.zt;
    s2_d.top    = s1_q.sel ? brighten_rgb(s1_q.top)  : s1_q.top;
    s2_d.side   = s1_q.sel ? brighten_rgb(s1_q.side) : s1_q.side;
  end

  // stage 3: drop fraction, limit by height on ordered axes
  always_comb begin
    s3_d.x0    = s2_q.x0;
    s3_d.x1    = s2_q.x1;
    s3_d.y0    = s2_q.y0;
    s3_d.y1    = s2_q.y1;
    s3_d.inv_x = s2_q.inv_x;
    s3_d.inv_y = s2_q.inv_y;
    s3_d.ox    = clamp_inset(s2_q.prod_x, s2_q.inv_x, s2_q.h);
    s3_d.oy    = clamp_inset(s2_q.prod_y, s2_q.inv_y, s2_q.h);
    s3_d.z0    = s2_q.z0;
    s3_d.zt    = s2_q.zt;
    s3_d.top   = s2_q.top;
    s3_d.side  = s2_q.side;
  end

  // stage 4: inset edges, left/front up, right/rear down, flipped if inverted
  always_comb begin
    s4_d.x0   = s3_q.x0;
    s4_d.x1   = s3_q.x1;
    s4_d.y0   = s3_q.y0;
    s4_d.y1   = s3_q.y1;
    s4_d.lx   = sat_move(s3_q.x0, !s3_q.inv_x, s3_q.ox);
    s4_d.rx   = sat_move(s3_q.x1,  s3_q.inv_x, s3_q.ox);
    s4_d.fy   = sat_move(s3_q.y0, !s3_q.inv_y, s3_q.oy);
    s4_d.ry   = sat_move(s3_q.y1,  s3_q.inv_y, s3_q.oy);
    s4_d.z0   = s3_q.z0;
    s4_d.zt   = s3_q.zt;
    s4_d.top  = s3_q.top;
    s4_d.side = s3_q.side;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
  end

  assign out_valid_o = v4_q;
  assign corners_o   = s4_q;

endmodule

/* hdl/bbve_emitter.sv */
// ----------------------------------------------------------------------------
// bbve_emitter
// Holds one resolved box and walks its 30 vertices, one beat per cycle while
// out_ready_i is high, loading the next box on the beat of the last vertex.
// ----------------------------------------------------------------------------
module bbve_emitter
  import bbve_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  corners_t corners_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vert_t    vert_o
);

  logic              valid_q, valid_d;
  logic [VIDX_W-1:0] cnt_q, cnt_d;
  corners_t          box_q;
  logic              beat;
  logic              last;
  logic              take;
  corner_e           crn;
  rgb_t              col;

  assign last        = cnt_q == VIDX_LAST;
  assign beat        = valid_q && out_ready_i;
  assign take        = !valid_q || (beat && last);
  assign in_ready_o  = take;
  assign out_valid_o = valid_q;

  // vertex counter and holding register
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (beat) begin
      cnt_d = last ? '0 : cnt_q + VIDX_W'(1);
    end
    if (take) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) box_q <= corners_i;
  end

  // corner select for the current vertex
  assign crn = vert_corner(cnt_q);
  assign col = (cnt_q >= VIDX_TOP) ? box_q.top : box_q.side;

  always_comb begin
    unique case (crn)
      CRN_BL:  begin vert_o.vert_x = box_q.x0; vert_o.vert_y = box_q.y1; end
      CRN_BR:  begin vert_o.vert_x = box_q.x1; vert_o.vert_y = box_q.y1; end
      CRN_FR:  begin vert_o.vert_x = box_q.x1; vert_o.vert_y = box_q.y0; end
      CRN_FL:  begin vert_o.vert_x = box_q.x0; vert_o.vert_y = box_q.y0; end
      CRN_TBL: begin vert_o.vert_x = box_q.lx; vert_o.vert_y = box_q.ry; end
      CRN_TBR: begin vert_o.vert_x = box_q.rx; vert_o.vert_y = box_q.ry; end
      CRN_TFR: begin vert_o.vert_x = box_q.rx; vert_o.vert_y = box_q.fy; end
      CRN_TFL: begin vert_o.vert_x = box_q.lx; vert_o.vert_y = box_q.fy; end
    endcase
    vert_o.vert_z      = (crn < CRN_TBL) ? box_q.z0 : box_q.zt;
    vert_o.out_red     = col.red;
    vert_o.out_green   = col.green;
    vert_o.out_blue    = col.blue;
    vert_o.last_vertex = last;
  end

endmodule

/* hdl/beveled_box_vertex_emitter_core.sv */
// ----------------------------------------------------------------------------
// beveled_box_vertex_emitter_core
// Turns one box beat into 30 triangle vertex beats: four shaded side quads
// and one inset top quad, two triangles each.
// ----------------------------------------------------------------------------
// usage
//   box_i is a valid/ready sink carrying one box per beat; vert_o is a
//   valid/ready source carrying one vertex per beat, last_vertex marks the
//   thirtieth vertex of each box.
//   path: the edge that accepts a box beat loads the first of four pipeline
//   stages, three more stages follow, then the emitter holding register; the
//   first vertex of a box is valid once the box reaches that register.
//   throughput: one vertex per cycle while vert_o.ready is high; the
//   emitter's vertex counter walking the held box sets this. Following
//   boxes wait in the four-stage pipeline and the next one is loaded on the
//   cycle that delivers the last vertex, so vertex beats run without gaps.
//   reset: rst_ni clears all valid bits and the vertex counter; nothing is
//   in flight afterward and no clearing pass is needed.
//   stall: when vert_o.ready is low the current vertex holds, the pipeline
//   fills and then box_i.ready drops; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module beveled_box_vertex_emitter_core
  import bbve_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bbve_box_if.sink    box_i,
  bbve_vert_if.source vert_o
);

  box_t     box;
  corners_t corners;
  logic     geo_valid;
  logic     geo_ready;
  vert_t    vert;

  // gather the box fields
  always_comb begin
    box.corner_x0     = box_i.corner_x0;
    box.corner_y0     = box_i.corner_y0;
    box.corner_x1     = box_i.corner_x1;
    box.corner_y1     = box_i.corner_y1;
    box.base_z        = box_i.base_z;
    box.box_height    = box_i.box_height;
    box.node_type     = box_i.node_type;
    box.color_red     = box_i.color_red;
    box.color_green   = box_i.color_green;
    box.color_blue    = box_i.color_blue;
    box.color_present = box_i.color_present;
    box.selected      = box_i.selected;
  end

  bbve_geom_pipe u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (box_i.valid),
    .in_ready_o  (box_i.ready),
    .box_i       (box),
    .out_valid_o (geo_valid),
    .out_ready_i (geo_ready),
    .corners_o   (corners)
  );

  bbve_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geo_valid),
    .in_ready_o  (geo_ready),
    .corners_i   (corners),
    .out_valid_o (vert_o.valid),
    .out_ready_i (vert_o.ready),
    .vert_o      (vert)
  );

  // spread the vertex fields
  assign vert_o.vert_x      = vert.vert_x;
  assign vert_o.vert_y      = vert.vert_y;
  assign vert_o.vert_z      = vert.vert_z;
  assign vert_o.out_red     = vert.out_red;
  assign vert_o.out_green   = vert.out_green;
  assign vert_o.out_blue    = vert.out_blue;
  assign vert_o.last_vertex = vert.last_vertex;

endmodule

/* bench/bbve_vertex_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbve_vertex_checker
// Watches the box and vertex channels of the beveled box vertex emitter.
// Every accepted box is expanded into its 30 expected vertices. Every
// accepted vertex beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module bbve_vertex_checker
  import bbve_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  bbve_box_if   box_mon,
  bbve_vert_if  vert_mon,
  output int    mismatch_cnt_o,
  output int    pending_o,
  output int    vert_cnt_o
);

  // wide signed math, room for extent times slant
  typedef logic signed [COORD_WIDTH+19:0] wide_t;

  localparam wide_t  COORD_HI   = (wide_t'(1) <<< (COORD_WIDTH - 1)) - wide_t'(1);
  localparam wide_t  COORD_LO   = -(wide_t'(1) <<< (COORD_WIDTH - 1));
  localparam longint Z_TOP      = (longint'(1) << ZW) - 1;
  localparam int     BEVEL_FRAC = 16;
  localparam int     FACES      = 5;
  localparam int     REPORT_MAX = 10;

  // slant per node type, Q0.16
  int slant_by_type [16] = '{0, 2097, 4194, 21823, 0, 0, 16384, 16384,
                             0, 0, 0, 0, 0, 0, 0, 0};

  // rear, right, front, left, top
  corner_e face_ring [FACES][4] = '{
    '{CRN_BL,  CRN_TBL, CRN_TBR, CRN_BR},
    '{CRN_BR,  CRN_TBR, CRN_TFR, CRN_FR},
    '{CRN_FR,  CRN_TFR, CRN_TFL, CRN_FL},
    '{CRN_FL,  CRN_TFL, CRN_TBL, CRN_BL},
    '{CRN_TFL, CRN_TFR, CRN_TBR, CRN_TBL}
  };

  // two triangles per quad: a,b,c then a,c,d
  int fan_pick [6] = '{0, 1, 2, 0, 2, 3};

  vert_t exp_verts_q [$];
  int    mismatch_cnt = 0;
  int    vert_cnt     = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign vert_cnt_o     = vert_cnt;

  function automatic coord_t clamp_coord(wide_t v);
    if (v > COORD_HI) return coord_t'(COORD_HI);
    if (v < COORD_LO) return coord_t'(COORD_LO);
    return coord_t'(v);
  endfunction

  // signed inset of one axis: negative on an inverted footprint
  function automatic wide_t bevel_inset(coord_t lo, coord_t hi, int slant,
                                        logic [HW-1:0] h);
    wide_t ext, prod;
    ext  = (hi < lo) ? wide_t'(lo) - wide_t'(hi) : wide_t'(hi) - wide_t'(lo);
    prod = (ext * wide_t'(slant)) >>> BEVEL_FRAC;
    if (hi < lo) return -prod;
    if (prod > wide_t'(h)) return wide_t'(h);
    return prod;
  endfunction

  // side shading, 0.65 with halves up
  function automatic logic [CHW-1:0] dim_chan(int c);
    return CHW'((c * 13 + 10) / 20);
  endfunction

  // selection highlight, 60% toward white with halves up
  function automatic logic [CHW-1:0] lift_chan(int c);
    return CHW'(c + ((255 - c) * 3 + 2) / 5);
  endfunction

  task automatic predict_box_vertices(box_t b);
    coord_t  cx [8];
    coord_t  cy [8];
    zval_t   cz [8];
    rgb_t    top, side, col;
    wide_t   ox, oy;
    coord_t  lx, rx, fy, ry;
    longint  zsum;
    zval_t   zt;
    vert_t   v;
    corner_e c;
    int      n;
    int      slant;

    // face colors
    if (b.color_present) top = '{red: b.color_red, green: b.color_green, blue: b.color_blue};
    else top = '{red: CHAN_FULL, green: CHAN_ZERO, blue: CHAN_ZERO};
    side.red   = dim_chan(top.red);
    side.green = dim_chan(top.green);
    side.blue  = dim_chan(top.blue);
    if (b.selected) begin
      top.red    = lift_chan(top.red);
      top.green  = lift_chan(top.green);
      top.blue   = lift_chan(top.blue);
      side.red   = lift_chan(side.red);
      side.green = lift_chan(side.green);
      side.blue  = lift_chan(side.blue);
    end

    // inset top ring
    slant = slant_by_type[b.node_type];
    ox = bevel_inset(b.corner_x0, b.corner_x1, slant, b.box_height);
    oy = bevel_inset(b.corner_y0, b.corner_y1, slant, b.box_height);
    lx = clamp_coord(wide_t'(b.corner_x0) + ox);
    rx = clamp_coord(wide_t'(b.corner_x1) - ox);
    fy = clamp_coord(wide_t'(b.corner_y0) + oy);
    ry = clamp_coord(wide_t'(b.corner_y1) - oy);

    // top height saturates
    zsum = longint'(b.base_z) + longint'(b.box_height);
    zt   = (zsum > Z_TOP) ? zval_t'(Z_TOP) : zval_t'(zsum);

    cx[CRN_BL]  = b.corner_x0; cy[CRN_BL]  = b.corner_y1; cz[CRN_BL]  = b.base_z;
    cx[CRN_BR]  = b.corner_x1; cy[CRN_BR]  = b.corner_y1; cz[CRN_BR]  = b.base_z;
    cx[CRN_FR]  = b.corner_x1; cy[CRN_FR]  = b.corner_y0; cz[CRN_FR]  = b.base_z;
    cx[CRN_FL]  = b.corner_x0; cy[CRN_FL]  = b.corner_y0; cz[CRN_FL]  = b.base_z;
    cx[CRN_TBL] = lx;          cy[CRN_TBL] = ry;          cz[CRN_TBL] = zt;
    cx[CRN_TBR] = rx;          cy[CRN_TBR] = ry;          cz[CRN_TBR] = zt;
    cx[CRN_TFR] = rx;          cy[CRN_TFR] = fy;          cz[CRN_TFR] = zt;
    cx[CRN_TFL] = lx;          cy[CRN_TFL] = fy;          cz[CRN_TFL] = zt;

    // walk the quads in emit order
    n = 0;
    for (int f = 0; f < FACES; f++) begin
      col = (f == FACES - 1) ? top : side;
      for (int t = 0; t < 6; t++) begin
        c = face_ring[f][fan_pick[t]];
        v.vert_x      = cx[c];
        v.vert_y      = cy[c];
        v.vert_z      = cz[c];
        v.out_red     = col.red;
        v.out_green   = col.green;
        v.out_blue    = col.blue;
        v.last_vertex = (n == NUM_VERTS - 1);
        exp_verts_q.push_back(v);
        n++;
      end
    end
  endtask

  // sample both channels on the clock edge
  always @(posedge clk_i) begin
    vert_t got, want;
    bit    bad;
    if (rst_ni) begin
      if (box_mon.valid && box_mon.ready) begin
        predict_box_vertices('{corner_x0: box_mon.corner_x0, corner_y0: box_mon.corner_y0,
                               corner_x1: box_mon.corner_x1, corner_y1: box_mon.corner_y1,
                               base_z: box_mon.base_z, box_height: box_mon.box_height,
                               node_type: box_mon.node_type, color_red: box_mon.color_red,
                               color_green: box_mon.color_green,
                               color_blue: box_mon.color_blue,
                               color_present: box_mon.color_present,
                               selected: box_mon.selected});
      end
      if (vert_mon.valid && vert_mon.ready) begin
        got = '{vert_x: vert_mon.vert_x, vert_y: vert_mon.vert_y, vert_z: vert_mon.vert_z,
                out_red: vert_mon.out_red, out_green: vert_mon.out_green,
                out_blue: vert_mon.out_blue, last_vertex: vert_mon.last_vertex};
        if (exp_verts_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("[%0t] vertex beat %0d arrived with no box pending", $time, vert_cnt);
        end else begin
          want = exp_verts_q.pop_front();
          bad  = (got.vert_x !== want.vert_x) || (got.vert_y !== want.vert_y) ||
                 (got.vert_z !== want.vert_z) || (got.out_red !== want.out_red) ||
                 (got.out_green !== want.out_green) || (got.out_blue !== want.out_blue) ||
                 (got.last_vertex !== want.last_vertex);
          if (bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("[%0t] vertex beat %0d mismatch", $time, vert_cnt);
              $display("  exp x=%0d y=%0d z=%0d rgb=%0d,%0d,%0d last=%0b",
                       want.vert_x, want.vert_y, want.vert_z, want.out_red,
                       want.out_green, want.out_blue, want.last_vertex);
              $display("  got x=%0d y=%0d z=%0d rgb=%0d,%0d,%0d last=%0b",
                       got.vert_x, got.vert_y, got.vert_z, got.out_red,
                       got.out_green, got.out_blue, got.last_vertex);
            end
          end
        end
        vert_cnt++;
      end
    end
    pending_o <= exp_verts_q.size();
  end

endmodule

/* bench/tb_beveled_box_vertex_emitter_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_beveled_box_vertex_emitter_core
// Drives boxes into the vertex emitter: a directed set of corner cases, then
// random boxes under four mixes of source idling and sink stalling. The
// checker beside the core predicts every vertex; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_beveled_box_vertex_emitter_core;
  import bbve_pkg::*;

  localparam int     CYCLE_LIMIT    = 400000;
  localparam int     DRAIN_CYCLES   = 40;
  localparam int     RESET_CYCLES   = 12;
  localparam int     RAND_PER_PHASE = 112;
  localparam int     NUM_PHASES     = 4;
  localparam int     NUM_TYPES      = 16;
  localparam coord_t COORD_MAX      = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN      = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam zval_t  Z_MAX          = '1;
  localparam logic [HW-1:0] H_MAX   = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int gap_pct     = 0;
  int stall_pct   = 0;
  int boxes_sent  = 0;
  int cycle_cnt   = 0;
  int mismatch_cnt, pending, vert_cnt;

  // idle and stall percentages per phase
  int gap_tab   [NUM_PHASES] = '{0, 60, 0, 16};
  int stall_tab [NUM_PHASES] = '{0, 0, 60, 16};

  bbve_box_if  box_if ();
  bbve_vert_if vert_if ();

  beveled_box_vertex_emitter_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if),
    .vert_o (vert_if)
  );

  bbve_vertex_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .box_mon        (box_if),
    .vert_mon       (vert_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .vert_cnt_o     (vert_cnt)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // vertex sink stalls at random
  always @(posedge clk_i) begin
    vert_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic box_t box_of(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                  zval_t z, logic [HW-1:0] h, logic [TW-1:0] t,
                                  logic [CHW-1:0] r, logic [CHW-1:0] g,
                                  logic [CHW-1:0] bl, bit present, bit sel);
    box_t b;
    b.corner_x0     = x0;
    b.corner_y0     = y0;
    b.corner_x1     = x1;
    b.corner_y1     = y1;
    b.base_z        = z;
    b.box_height    = h;
    b.node_type     = t;
    b.color_red     = r;
    b.color_green   = g;
    b.color_blue    = bl;
    b.color_present = present;
    b.selected      = sel;
    return b;
  endfunction

  // mostly ordered footprints of mixed size, some inverted, some raw bits
  function automatic box_t rand_box();
    box_t b;
    int   shape, ctr_x, ctr_y, span_x, span_y;
    shape = $urandom_range(99);
    b.node_type     = ($urandom_range(3) == 0) ? TW'($urandom_range(15))
                                               : TW'($urandom_range(8));
    b.color_red     = CHW'($urandom);
    b.color_green   = CHW'($urandom);
    b.color_blue    = CHW'($urandom);
    b.color_present = ($urandom_range(7) != 0);
    b.selected      = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       b.base_z = ZW'($urandom);
      1:       b.base_z = Z_MAX - ZW'($urandom_range(0, 1 << 24));
      default: b.base_z = ZW'($urandom_range(0, 1 << 28));
    endcase
    case ($urandom_range(9))
      0, 1, 2:    b.box_height = HW'($urandom_range(0, 2047));
      3, 4, 5, 6: b.box_height = HW'($urandom_range(0, 1 << 20));
      default:    b.box_height = HW'($urandom);
    endcase
    if (shape < 12) begin
      b.corner_x0 = $urandom;
      b.corner_y0 = $urandom;
      b.corner_x1 = $urandom;
      b.corner_y1 = $urandom;
    end else begin
      ctr_x  = $urandom_range(0, 1 << 27) - (1 << 26);
      ctr_y  = $urandom_range(0, 1 << 27) - (1 << 26);
      span_x = $urandom_range(0, 1 << $urandom_range(2, 26));
      span_y = $urandom_range(0, 1 << $urandom_range(2, 26));
      b.corner_x0 = ctr_x;
      b.corner_x1 = ctr_x + span_x;
      b.corner_y0 = ctr_y;
      b.corner_y1 = ctr_y + span_y;
      // inverted footprints: x only, both, y only
      if (shape < 17)
        {b.corner_x0, b.corner_x1} = {b.corner_x1, b.corner_x0};
      if (shape >= 15 && shape < 22)
        {b.corner_y0, b.corner_y1} = {b.corner_y1, b.corner_y0};
    end
    return b;
  endfunction

  // one box beat, with random idle cycles ahead of it
  task automatic send_box(box_t b);
    while ($urandom_range(99) < gap_pct) begin
      box_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    box_if.valid         <= 1'b1;
    box_if.corner_x0     <= b.corner_x0;
    box_if.corner_y0     <= b.corner_y0;
    box_if.corner_x1     <= b.corner_x1;
    box_if.corner_y1     <= b.corner_y1;
    box_if.base_z        <= b.base_z;
    box_if.box_height    <= b.box_height;
    box_if.node_type     <= b.node_type;
    box_if.color_red     <= b.color_red;
    box_if.color_green   <= b.color_green;
    box_if.color_blue    <= b.color_blue;
    box_if.color_present <= b.color_present;
    box_if.selected      <= b.selected;
    do @(posedge clk_i); while (!box_if.ready);
    boxes_sent++;
  endtask

  initial begin
    box_t b;
    int   directed;

    box_if.valid         <= 1'b0;
    box_if.corner_x0     <= '0;
    box_if.corner_y0     <= '0;
    box_if.corner_x1     <= '0;
    box_if.corner_y1     <= '0;
    box_if.base_z        <= '0;
    box_if.box_height    <= '0;
    box_if.node_type     <= '0;
    box_if.color_red     <= '0;
    box_if.color_green   <= '0;
    box_if.color_blue    <= '0;
    box_if.color_present <= 1'b0;
    box_if.selected      <= 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases, no idling
    // degenerate box at the origin, fallback color
    send_box(box_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // widest footprint, tallest box, top height saturates, white and selected
    send_box(box_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, Z_MAX, H_MAX, 3,
                    8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // fully inverted footprint, inset not limited by the zero height
    send_box(box_of(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0, 0, 3,
                    8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    // inverted on x only
    send_box(box_of(5000, -3000, -7000, 9000, 1000, 400, 6, 12, 200, 99, 1'b1, 1'b0));
    // inverted on y only
    send_box(box_of(-8000, 7000, 6000, -6000, 256, 2000, 7, 128, 64, 32, 1'b1, 1'b1));
    // inset limited by a low box
    send_box(box_of(-(1 << 24), -(1 << 24), 1 << 24, 1 << 24, 77, 100, 3,
                    200, 10, 150, 1'b1, 1'b0));
    // zero extent
    send_box(box_of(100, 100, 100, 100, 50, 3000, 2, 1, 2, 3, 1'b1, 1'b0));
    // fallback color while selected
    send_box(box_of(-500, -400, 600, 700, 10, 80, 1, 8'hAA, 8'h55, 8'h0F, 1'b0, 1'b1));
    // top height just past the ceiling
    send_box(box_of(0, 0, 4096, 4096, Z_MAX - 5, 10, 6, 90, 91, 92, 1'b1, 1'b0));
    // every node type, the unlisted ones too
    for (int t = 0; t < NUM_TYPES; t++) begin
      b = rand_box();
      b.node_type = TW'(t);
      send_box(b);
    end
    directed = boxes_sent;

    // random boxes under each idle mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_pct   = gap_tab[ph];
      stall_pct = stall_tab[ph];
      for (int i = 0; i < RAND_PER_PHASE; i++) send_box(rand_box());
    end
    box_if.valid <= 1'b0;

    // drain, then give stray beats a chance to show up
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("boxes: %0d (%0d directed), vertex beats checked: %0d, cycles: %0d",
             boxes_sent, directed, vert_cnt, cycle_cnt);
    $display("idle mixes: none, source 60%%, sink 60%%, both 16%%; mismatches: %0d",
             mismatch_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bbve_pkg.sv
hdl/bbve_ifs.sv
hdl/bbve_geom_pipe.sv
hdl/bbve_emitter.sv
hdl/beveled_box_vertex_emitter_core.sv
bench/bbve_vertex_checker.sv
bench/tb_beveled_box_vertex_emitter_core.sv
